// ===== rtl/core/ldmc_pkg.sv =====
`default_nettype none

package ldmc_pkg;

	localparam int unsigned MS_W     = 16;
	localparam int unsigned MINUTE_W = 11;
	localparam int unsigned CMD_W    = 2;
	localparam int unsigned EVENT_W  = 3;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [MS_W-1:0] MS_MAX = '1;

	localparam logic [MS_W-1:0]     DEBOUNCE_RST   = 16'd500;
	localparam logic [MS_W-1:0]     MAX_TRAVEL_RST = 16'd22000;
	localparam logic [MS_W-1:0]     OVERRUN_RST    = 16'd1000;
	localparam logic [MINUTE_W-1:0] SUNRISE_RST    = 11'd0;
	localparam logic [MINUTE_W-1:0] SUNSET_RST     = 11'd0;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_TRAVEL  = 2'd1,
		PH_OVERRUN = 2'd2
	} phase_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK  = 2'd0,
		CMD_OPEN  = 2'd1,
		CMD_CLOSE = 2'd2,
		CMD_TIME  = 2'd3
	} cmd_t;

	typedef enum logic [EVENT_W-1:0] {
		EV_NONE    = 3'd0,
		EV_OPEN    = 3'd1,
		EV_CLOSE   = 3'd2,
		EV_LIMIT   = 3'd3,
		EV_TIMEOUT = 3'd4,
		EV_STOP    = 3'd5,
		EV_IGNORED = 3'd6
	} event_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEBOUNCE   = 3'd0,
		CFG_MAX_TRAVEL = 3'd1,
		CFG_OVERRUN    = 3'd2,
		CFG_SUNRISE    = 3'd3,
		CFG_SUNSET     = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [MS_W-1:0]     debounce_ms;
		logic [MS_W-1:0]     max_travel_ms;
		logic [MS_W-1:0]     overrun_ms;
		logic [MINUTE_W-1:0] sunrise_minute;
		logic [MINUTE_W-1:0] sunset_minute;
	} cfg_t;

	typedef struct packed {
		phase_t          phase;
		logic            dir_up;
		logic            button_prev;
		logic [MS_W-1:0] press_age_ms;
		logic [MS_W-1:0] phase_timer_ms;
	} ctrl_state_t;

	typedef struct packed {
		logic [CMD_W-1:0]    cmd;
		logic                button_down;
		logic                top_reached;
		logic                bottom_reached;
		logic [MINUTE_W-1:0] minute_of_day;
	} item_t;

	typedef struct packed {
		logic         motor_enable;
		logic         drive_up;
		logic         drive_down;
		logic         last_dir_up;
		logic [EVENT_W-1:0] event_res;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/core/ldmc_in_if.sv =====
`default_nettype none

interface ldmc_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic        button_down;
	logic        top_reached;
	logic        bottom_reached;
	logic [10:0] minute_of_day;

	modport source (output valid, cmd, button_down, top_reached, bottom_reached,
		minute_of_day, input ready);
	modport sink (input valid, cmd, button_down, top_reached, bottom_reached,
		minute_of_day, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ldmc_out_if.sv =====
`default_nettype none

interface ldmc_out_if;
	logic       valid;
	logic       ready;
	logic       motor_enable;
	logic       drive_up;
	logic       drive_down;
	logic       last_dir_up;
	logic [2:0] event_res;

	modport source (output valid, motor_enable, drive_up, drive_down, last_dir_up,
		event_res, input ready);
	modport sink (input valid, motor_enable, drive_up, drive_down, last_dir_up,
		event_res, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ldmc_step.sv =====
`default_nettype none

module ldmc_step
	import ldmc_pkg::*;
(
	input  var ctrl_state_t cur,
	input  var item_t       item,
	input  var cfg_t        cfg,
	output ctrl_state_t     nxt,
	output result_t         res
);

	logic            edge_seen;
	logic            press;
	logic            limit_hit;
	logic            day;
	logic [MS_W-1:0] age_inc;
	logic [MS_W-1:0] timer_inc;
	event_t          ev;

	assign age_inc   = (cur.press_age_ms != MS_MAX) ? cur.press_age_ms + 1'b1
		: cur.press_age_ms;
	assign timer_inc = (cur.phase_timer_ms != MS_MAX) ? cur.phase_timer_ms + 1'b1
		: cur.phase_timer_ms;
	assign edge_seen = item.button_down && !cur.button_prev;
	assign press     = edge_seen && (age_inc >= cfg.debounce_ms);
	assign limit_hit = cur.dir_up ? item.top_reached : item.bottom_reached;
	assign day       = (item.minute_of_day >= cfg.sunrise_minute)
		&& (item.minute_of_day < cfg.sunset_minute);

	always_comb begin
		nxt = cur;
		ev  = EV_NONE;
		case (item.cmd)
			CMD_TICK: begin
				nxt.button_prev  = item.button_down;
				nxt.press_age_ms = age_inc;
				if (press) begin
					nxt.press_age_ms = '0;
					if (cur.phase != PH_IDLE) begin
						nxt.phase          = PH_IDLE;
						nxt.phase_timer_ms = '0;
						ev                 = EV_STOP;
					end else if (!(item.top_reached && item.bottom_reached)) begin
						// direction: away from the active limit, else reverse last travel
						nxt.phase          = PH_TRAVEL;
						nxt.phase_timer_ms = '0;
						if (item.top_reached) begin
							nxt.dir_up = 1'b0;
						end else if (item.bottom_reached) begin
							nxt.dir_up = 1'b1;
						end else begin
							nxt.dir_up = !cur.dir_up;
						end
						ev = nxt.dir_up ? EV_OPEN : EV_CLOSE;
					end
				end else if (cur.phase == PH_TRAVEL) begin
					if (limit_hit || (timer_inc >= cfg.max_travel_ms)) begin
						nxt.phase_timer_ms = '0;
						nxt.phase = (cfg.overrun_ms == '0) ? PH_IDLE : PH_OVERRUN;
						ev = limit_hit ? EV_LIMIT : EV_TIMEOUT;
					end else begin
						nxt.phase_timer_ms = timer_inc;
					end
				end else if (cur.phase == PH_OVERRUN) begin
					if (timer_inc >= cfg.overrun_ms) begin
						nxt.phase          = PH_IDLE;
						nxt.phase_timer_ms = '0;
						ev                 = EV_STOP;
					end else begin
						nxt.phase_timer_ms = timer_inc;
					end
				end
			end
			default: begin
				if (cur.phase != PH_IDLE) begin
					ev = EV_IGNORED;
				end else begin
					nxt.phase          = PH_TRAVEL;
					nxt.phase_timer_ms = '0;
					case (item.cmd)
						CMD_OPEN:  nxt.dir_up = 1'b1;
						CMD_CLOSE: nxt.dir_up = 1'b0;
						default:   nxt.dir_up = day;
					endcase
					ev = nxt.dir_up ? EV_OPEN : EV_CLOSE;
				end
			end
		endcase
	end

	always_comb begin
		res.motor_enable = (nxt.phase != PH_IDLE);
		res.drive_up     = res.motor_enable && nxt.dir_up;
		res.drive_down   = res.motor_enable && !nxt.dir_up;
		res.last_dir_up  = nxt.dir_up;
		res.event_res    = ev;
	end

endmodule

`default_nettype wire

// ===== rtl/core/limit_switch_door_motor_controller_unit.sv =====
// datapath: an accepted transaction goes to the input register, then through the update
// logic to the result register, which it enters only once that register is free
// throughput: one transaction per cycle while the output is ready; the result and
// input registers let a new item enter while a finished result still waits on the output
// reset (arst_n low, asynchronous): idle with no result valid, direction down, counters
// cleared, configuration back to debounce 500, travel 22000, overrun 1000, minutes 0
`default_nettype none

module limit_switch_door_motor_controller_unit
	import ldmc_pkg::*;
(
	input  wire                  clk,
	input  wire                  arst_n,
	ldmc_in_if.sink              in_ch,
	ldmc_out_if.source           out_ch,
	input  wire                  cfg_we,
	input  wire [CFG_IDX_W-1:0]  cfg_index,
	input  wire [CFG_DATA_W-1:0] cfg_data
);

	// input stage: one registered item waiting for the update logic
	item_t       in_s1;
	logic        in_valid_s1;

	// result stage
	result_t     res_s2;
	logic        res_valid_s2;

	// controller state and configuration
	ctrl_state_t state_q;
	cfg_t        cfg_q;

	ctrl_state_t state_d;
	result_t     res_d;
	logic        advance;
	logic        in_fire;

	// item moves on when the result register is empty or being emptied this cycle
	assign advance      = in_valid_s1 && (!res_valid_s2 || out_ch.ready);
	assign in_ch.ready  = !in_valid_s1 || advance;
	assign in_fire      = in_ch.valid && in_ch.ready;

	// the whole state update for one item
	ldmc_step u_step (
		.cur  (state_q),
		.item (in_s1),
		.cfg  (cfg_q),
		.nxt  (state_d),
		.res  (res_d)
	);

	// valid flags, state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1          <= 1'b0;
			res_valid_s2         <= 1'b0;
			state_q.phase          <= PH_IDLE;
			state_q.dir_up         <= 1'b0;
			state_q.button_prev    <= 1'b0;
			state_q.press_age_ms   <= '0;
			state_q.phase_timer_ms <= '0;
			cfg_q.debounce_ms    <= DEBOUNCE_RST;
			cfg_q.max_travel_ms  <= MAX_TRAVEL_RST;
			cfg_q.overrun_ms     <= OVERRUN_RST;
			cfg_q.sunrise_minute <= SUNRISE_RST;
			cfg_q.sunset_minute  <= SUNSET_RST;
		end else begin
			if (in_fire) begin
				in_valid_s1 <= 1'b1;
			end else if (advance) begin
				in_valid_s1 <= 1'b0;
			end

			if (advance) begin
				res_valid_s2 <= 1'b1;
				state_q      <= state_d;
			end else if (out_ch.ready) begin
				res_valid_s2 <= 1'b0;
			end

			// user must write only while idle: not enforced, no interlock with the update
			if (cfg_we) begin
				case (cfg_index)
					CFG_DEBOUNCE:   cfg_q.debounce_ms    <= cfg_data[MS_W-1:0];
					CFG_MAX_TRAVEL: cfg_q.max_travel_ms  <= cfg_data[MS_W-1:0];
					CFG_OVERRUN:    cfg_q.overrun_ms     <= cfg_data[MS_W-1:0];
					CFG_SUNRISE:    cfg_q.sunrise_minute <= cfg_data[MINUTE_W-1:0];
					CFG_SUNSET:     cfg_q.sunset_minute  <= cfg_data[MINUTE_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (in_fire) begin
			in_s1.cmd            <= in_ch.cmd;
			in_s1.button_down    <= in_ch.button_down;
			in_s1.top_reached    <= in_ch.top_reached;
			in_s1.bottom_reached <= in_ch.bottom_reached;
			in_s1.minute_of_day  <= in_ch.minute_of_day;
		end
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	assign out_ch.valid        = res_valid_s2;
	assign out_ch.motor_enable = res_s2.motor_enable;
	assign out_ch.drive_up     = res_s2.drive_up;
	assign out_ch.drive_down   = res_s2.drive_down;
	assign out_ch.last_dir_up  = res_s2.last_dir_up;
	assign out_ch.event_res    = res_s2.event_res;

endmodule

`default_nettype wire

// ===== rtl/core/ldmc_checker.sv =====
`default_nettype none

module ldmc_checker
	import ldmc_pkg::*;
(
	input wire       clk,
	input wire       arst_n,
	input wire       out_valid,
	input wire       out_ready,
	input wire       motor_enable,
	input wire       drive_up,
	input wire       drive_down,
	input wire       last_dir_up,
	input wire [2:0] event_res
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_res)
		&& $stable(motor_enable))
		else $error("result changed while stalled");

	// bridge inputs follow enable and direction
	a_bridge: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (drive_up == (motor_enable && last_dir_up))
		&& (drive_down == (motor_enable && !last_dir_up)))
		else $error("bridge inputs inconsistent");

	// a started move runs in its direction
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_res == EV_OPEN || event_res == EV_CLOSE)
		|-> motor_enable && (last_dir_up == (event_res == EV_OPEN)))
		else $error("start event without matching drive");

	// ignored commands and stops only happen around a running motor
	a_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == EV_IGNORED |-> motor_enable)
		else $error("command ignored while motor off");

	a_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == EV_STOP |-> !motor_enable)
		else $error("stop event with motor on");

endmodule

bind limit_switch_door_motor_controller_unit ldmc_checker u_ldmc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.motor_enable (out_ch.motor_enable),
	.drive_up     (out_ch.drive_up),
	.drive_down   (out_ch.drive_down),
	.last_dir_up  (out_ch.last_dir_up),
	.event_res    (out_ch.event_res)
);

`default_nettype wire
